### rtl/prtg_pkg.sv
`timescale 1ns / 1ps

package prtg_pkg;

	// defaults for the top level parameters
	localparam int MAX_PERIOD_DEF  = 65536;
	localparam int SAMPLE_BITS_DEF = 16;

	// channel count clamp
	localparam int MAX_CHANNELS = 8;

	// configuration register widths
	localparam int PER_W      = 17;
	localparam int RAMP_W     = 17;
	localparam int OFS_W      = 16;
	localparam int AMP_W      = 17;
	localparam int CIDX_W     = 3;
	localparam int CCNT_W     = 4;
	localparam int DLY_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// shared divider: fixed number of quotient bits, dividend and divisor widths
	localparam int DIV_QB = 20;
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 18;

	// shared multiplier operand and product widths
	localparam int MUL_AW = 18;
	localparam int MUL_BW = 19;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD,
		CFG_RAMP,
		CFG_OFFSET,
		CFG_AMPLITUDE,
		CFG_CHAN_INDEX,
		CFG_CHAN_COUNT,
		CFG_EXTRA_DELAY
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CC_DIV,
		ST_CC_WAIT,
		ST_SH_MUL,
		ST_SH_ADD,
		ST_MOD_DIV,
		ST_MOD_WAIT,
		ST_MOD_FIX,
		ST_PHASE,
		ST_MUL,
		ST_ABS,
		ST_VAL_DIV,
		ST_VAL_WAIT,
		ST_OUT
	} state_t;

	// divider operand source
	typedef enum logic [1:0] {
		DIV_CC,
		DIV_MOD,
		DIV_VAL
	} div_sel_t;

	// multiplier operand source
	typedef enum logic {
		MUL_SHIFT,
		MUL_VAL
	} mul_sel_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic     ready;
		logic     div_start;
		div_sel_t div_sel;
		mul_sel_t mul_sel;
		logic     ld_prod;
		logic     ld_d;
		logic     ld_shift;
		logic     ld_phase;
		logic     ld_abs;
		logic     ld_out;
	} ctl_t;

	// datapath to sequencer status
	typedef struct packed {
		logic in_fire;
		logic dirty;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

### rtl/prtg_tick_if.sv
`timescale 1ns / 1ps

interface prtg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

### rtl/prtg_sample_if.sv
`timescale 1ns / 1ps

interface prtg_sample_if #(
	parameter int SAMPLE_BITS = prtg_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          period_end;
	logic                          clipped;

	modport source (output valid, output sample_value, output period_end, output clipped,
		input ready);
	modport sink (input valid, input sample_value, input period_end, input clipped,
		output ready);
endinterface

### rtl/prtg_div.sv
`timescale 1ns / 1ps

module prtg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [prtg_pkg::DIV_NW-1:0] dividend,
	input  logic [prtg_pkg::DIV_DW-1:0] divisor,
	output logic [prtg_pkg::DIV_QB-1:0] quot,
	output logic [prtg_pkg::DIV_DW-1:0] rem,
	output logic                        done
);
	localparam int NW    = prtg_pkg::DIV_NW;
	localparam int QB    = prtg_pkg::DIV_QB;
	localparam int SH_W  = prtg_pkg::DIV_DW + QB;
	localparam int CNT_W = $clog2(QB);

	logic [NW-1:0]    rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [QB-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	// one restoring step: compare against the shifted divisor
	assign ge = SH_W'(rem_q) >= dsh_q;

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// partial remainder, shifted divisor and quotient bits
	// first step weighs the top quotient bit, divisor shifted by QB-1
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {1'b0, divisor, {(QB-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NW-1:0];
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q[prtg_pkg::DIV_DW-1:0];
	assign done = done_q;
endmodule

### rtl/prtg_seq.sv
`timescale 1ns / 1ps

module prtg_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  prtg_pkg::stat_t stat,
	output prtg_pkg::ctl_t  ctl
);
	prtg_pkg::state_t state_q;
	prtg_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prtg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prtg_pkg::ST_IDLE: begin
				if (stat.in_fire) begin
					state_d = stat.dirty ? prtg_pkg::ST_CC_DIV : prtg_pkg::ST_PHASE;
				end
			end
			prtg_pkg::ST_CC_DIV:  state_d = prtg_pkg::ST_CC_WAIT;
			prtg_pkg::ST_CC_WAIT: begin
				if (stat.div_done) begin
					state_d = prtg_pkg::ST_SH_MUL;
				end
			end
			prtg_pkg::ST_SH_MUL:   state_d = prtg_pkg::ST_SH_ADD;
			prtg_pkg::ST_SH_ADD:   state_d = prtg_pkg::ST_MOD_DIV;
			prtg_pkg::ST_MOD_DIV:  state_d = prtg_pkg::ST_MOD_WAIT;
			prtg_pkg::ST_MOD_WAIT: begin
				if (stat.div_done) begin
					state_d = prtg_pkg::ST_MOD_FIX;
				end
			end
			prtg_pkg::ST_MOD_FIX:  state_d = prtg_pkg::ST_PHASE;
			prtg_pkg::ST_PHASE:    state_d = prtg_pkg::ST_MUL;
			prtg_pkg::ST_MUL:      state_d = prtg_pkg::ST_ABS;
			prtg_pkg::ST_ABS:      state_d = prtg_pkg::ST_VAL_DIV;
			prtg_pkg::ST_VAL_DIV:  state_d = prtg_pkg::ST_VAL_WAIT;
			prtg_pkg::ST_VAL_WAIT: begin
				if (stat.div_done) begin
					state_d = prtg_pkg::ST_OUT;
				end
			end
			prtg_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_d = prtg_pkg::ST_IDLE;
				end
			end
			default: state_d = prtg_pkg::ST_IDLE;
		endcase
	end

	// controls per state
	always_comb begin
		ctl           = '0;
		ctl.div_sel   = prtg_pkg::DIV_VAL;
		ctl.mul_sel   = prtg_pkg::MUL_VAL;
		unique case (state_q)
			prtg_pkg::ST_IDLE:   ctl.ready = 1'b1;
			prtg_pkg::ST_CC_DIV: begin
				ctl.div_start = 1'b1;
				ctl.div_sel   = prtg_pkg::DIV_CC;
			end
			prtg_pkg::ST_CC_WAIT: ;
			prtg_pkg::ST_SH_MUL: begin
				ctl.mul_sel = prtg_pkg::MUL_SHIFT;
				ctl.ld_prod = 1'b1;
			end
			prtg_pkg::ST_SH_ADD:  ctl.ld_d = 1'b1;
			prtg_pkg::ST_MOD_DIV: begin
				ctl.div_start = 1'b1;
				ctl.div_sel   = prtg_pkg::DIV_MOD;
			end
			prtg_pkg::ST_MOD_WAIT: ;
			prtg_pkg::ST_MOD_FIX:  ctl.ld_shift = 1'b1;
			prtg_pkg::ST_PHASE:    ctl.ld_phase = 1'b1;
			prtg_pkg::ST_MUL:      ctl.ld_prod  = 1'b1;
			prtg_pkg::ST_ABS:      ctl.ld_abs   = 1'b1;
			prtg_pkg::ST_VAL_DIV:  ctl.div_start = 1'b1;
			prtg_pkg::ST_VAL_WAIT: ;
			prtg_pkg::ST_OUT:      ctl.ld_out = stat.out_free;
			default: ;
		endcase
	end
endmodule

### rtl/phased_triangle_ramp_generator.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// tick      in   valid/ready   restart
// sample    out  valid/ready   sample_value, period_end, clipped
// cfg       in   cfg_wr_en     cfg_index, cfg_data (no read-back)
//
// A request spends most of its way to the result register in the 20-step restoring
// divider that forms the rounded ramp value; a new request is taken only when idle.
// After reset or any register write, the first request also recomputes the phase
// shift on the same divider (two more divisions).
// tick.ready is high only while the sequencer is idle; a waiting result holds the
// sequencer in ST_OUT. arst_n resets sequencer, counter, configuration, output valid.

module phased_triangle_ramp_generator #(
	parameter int MAX_PERIOD  = prtg_pkg::MAX_PERIOD_DEF,
	parameter int SAMPLE_BITS = prtg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	prtg_tick_if.sink                       tick,
	prtg_sample_if.source                   sample,
	input  logic                            cfg_wr_en,
	input  logic [prtg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prtg_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int PER_W      = prtg_pkg::PER_W;
	localparam int PER_LIMIT  = (1 << PER_W) - 1;
	localparam int MAXP_CLAMP = (MAX_PERIOD > PER_LIMIT) ? PER_LIMIT : MAX_PERIOD;
	localparam int CNT_W      = $clog2(MAXP_CLAMP);
	localparam int T_W        = 20;
	localparam int D_W        = T_W + 1;
	localparam int M_W        = PER_W + 2;
	localparam int Q_W        = prtg_pkg::DIV_QB + 1;
	localparam int VW         = ((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18) + 1;
	localparam logic signed [VW-1:0] VMAX = VW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [VW-1:0] VMIN = VW'(-(1 << (SAMPLE_BITS - 1)));

	// configuration registers
	logic [PER_W-1:0]                     period_q;
	logic [prtg_pkg::RAMP_W-1:0]          ramp_q;
	logic signed [prtg_pkg::OFS_W-1:0]    offset_q;
	logic signed [prtg_pkg::AMP_W-1:0]    amp_q;
	logic [prtg_pkg::CIDX_W-1:0]          cidx_q;
	logic [prtg_pkg::CCNT_W-1:0]          ccnt_q;
	logic signed [prtg_pkg::DLY_W-1:0]    dly_q;
	logic                                 dirty_q;

	// per request state
	logic [CNT_W-1:0]                     cnt_q;
	logic [PER_W-1:0]                     j_q;
	logic                                 pe_q;
	logic signed [prtg_pkg::MUL_PW-1:0]   prod_q;
	logic signed [D_W-1:0]                d_q;
	logic [PER_W-1:0]                     shift_q;
	logic signed [M_W-1:0]                m_q;
	logic [PER_W-1:0]                     h_q;
	logic                                 neg_q;
	logic [prtg_pkg::DIV_NW-1:0]          nabs_q;

	// output register
	logic                                 ovalid_q;
	logic signed [SAMPLE_BITS-1:0]        oval_q;
	logic                                 ope_q;
	logic                                 oclip_q;

	prtg_pkg::ctl_t                       ctl;
	prtg_pkg::stat_t                      stat;

	logic [PER_W-1:0]                     p_eff;
	logic [PER_W-1:0]                     r_eff;
	logic [prtg_pkg::CCNT_W-1:0]          cc_eff;
	logic                                 tick_fire;
	logic [CNT_W-1:0]                     cnt_eff;
	logic [PER_W-1:0]                     j_c;
	logic [PER_W:0]                       j1;
	logic [prtg_pkg::DIV_NW-1:0]          div_n;
	logic [prtg_pkg::DIV_DW-1:0]          div_d;
	logic [prtg_pkg::DIV_QB-1:0]          div_quot;
	logic [prtg_pkg::DIV_DW-1:0]          div_rem;
	logic                                 div_done;
	logic signed [prtg_pkg::MUL_AW-1:0]   mul_a;
	logic signed [prtg_pkg::MUL_BW-1:0]   mul_b;
	logic signed [prtg_pkg::MUL_PW-1:0]   prod_c;
	logic signed [D_W-1:0]                d_c;
	logic [T_W-1:0]                       dabs;
	logic [PER_W-1:0]                     rem_p;
	logic [PER_W:0]                       kd;
	logic [PER_W-1:0]                     k;
	logic [PER_W-1:0]                     fall;
	logic                                 rising;
	logic signed [M_W-1:0]                m_c;
	logic signed [prtg_pkg::MUL_PW-1:0]   n_c;
	logic [Q_W-1:0]                       qmag;
	logic signed [Q_W-1:0]                qv;
	logic signed [VW-1:0]                 v;
	logic signed [VW-1:0]                 v_sat;
	logic                                 clip_c;
	logic                                 out_free;

	assign tick_fire = tick.valid && tick.ready;
	assign out_free  = !ovalid_q || sample.ready;

	// clamped period, ramp and channel count
	always_comb begin
		if (period_q == '0) begin
			p_eff = PER_W'(1);
		end else if (period_q > PER_W'(MAXP_CLAMP)) begin
			p_eff = PER_W'(MAXP_CLAMP);
		end else begin
			p_eff = period_q;
		end
		r_eff = (ramp_q > p_eff) ? p_eff : ramp_q;
		if (ccnt_q == '0) begin
			cc_eff = prtg_pkg::CCNT_W'(1);
		end else if (ccnt_q > prtg_pkg::CCNT_W'(prtg_pkg::MAX_CHANNELS)) begin
			cc_eff = prtg_pkg::CCNT_W'(prtg_pkg::MAX_CHANNELS);
		end else begin
			cc_eff = ccnt_q;
		end
	end

	// configuration writes; any write forces the phase shift to be recomputed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PER_W'(1024);
			ramp_q   <= '0;
			offset_q <= '0;
			amp_q    <= '0;
			cidx_q   <= '0;
			ccnt_q   <= prtg_pkg::CCNT_W'(1);
			dly_q    <= '0;
			dirty_q  <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				dirty_q <= 1'b1;
				unique case (prtg_pkg::cfg_idx_t'(cfg_index))
					prtg_pkg::CFG_PERIOD:      period_q <= cfg_data[PER_W-1:0];
					prtg_pkg::CFG_RAMP:        ramp_q <= cfg_data[prtg_pkg::RAMP_W-1:0];
					prtg_pkg::CFG_OFFSET:      offset_q <= signed'(cfg_data[prtg_pkg::OFS_W-1:0]);
					prtg_pkg::CFG_AMPLITUDE:   amp_q <= signed'(cfg_data[prtg_pkg::AMP_W-1:0]);
					prtg_pkg::CFG_CHAN_INDEX:  cidx_q <= cfg_data[prtg_pkg::CIDX_W-1:0];
					prtg_pkg::CFG_CHAN_COUNT:  ccnt_q <= cfg_data[prtg_pkg::CCNT_W-1:0];
					prtg_pkg::CFG_EXTRA_DELAY: dly_q <= signed'(cfg_data[prtg_pkg::DLY_W-1:0]);
					default: ;
				endcase
			end else if (ctl.ld_shift) begin
				dirty_q <= 1'b0;
			end
		end
	end

	// sample counter position for this request
	always_comb begin
		cnt_eff = tick.restart ? '0 : cnt_q;
		j_c     = (PER_W'(cnt_eff) >= p_eff) ? '0 : PER_W'(cnt_eff);
		j1      = {1'b0, j_c} + (PER_W + 1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (tick_fire) begin
			cnt_q <= (j1 >= {1'b0, p_eff}) ? '0 : j1[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			j_q  <= j_c;
			pe_q <= (j1 == {1'b0, p_eff});
		end
	end

	// divider operand select
	always_comb begin
		case (ctl.div_sel)
			prtg_pkg::DIV_CC: begin
				div_n = prtg_pkg::DIV_NW'(p_eff);
				div_d = prtg_pkg::DIV_DW'(cc_eff);
			end
			prtg_pkg::DIV_MOD: begin
				div_n = prtg_pkg::DIV_NW'(dabs);
				div_d = prtg_pkg::DIV_DW'(p_eff);
			end
			prtg_pkg::DIV_VAL: begin
				div_n = nabs_q;
				div_d = {h_q, 1'b0};
			end
			default: begin
				div_n = '0;
				div_d = '0;
			end
		endcase
	end

	prtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	// shared multiplier: channel index times period slice, or amplitude times ramp term
	always_comb begin
		case (ctl.mul_sel)
			prtg_pkg::MUL_SHIFT: begin
				mul_a = signed'(prtg_pkg::MUL_AW'(div_quot[PER_W-1:0]));
				mul_b = signed'(prtg_pkg::MUL_BW'(cidx_q));
			end
			default: begin
				mul_a = prtg_pkg::MUL_AW'(amp_q);
				mul_b = m_q;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// phase shift: slice times index plus extra delay, then reduced modulo period
	assign d_c   = signed'({1'b0, prod_q[T_W-1:0]}) + D_W'(dly_q);
	assign dabs  = T_W'(d_q[D_W-1] ? -d_q : d_q);
	assign rem_p = div_rem[PER_W-1:0];

	// phase within the period and the ramp term
	always_comb begin
		kd     = {1'b0, j_q} - {1'b0, shift_q};
		k      = kd[PER_W] ? (kd[PER_W-1:0] + p_eff) : kd[PER_W-1:0];
		fall   = p_eff - r_eff;
		rising = k < r_eff;
		if (rising) begin
			m_c = signed'({1'b0, k, 1'b0}) - signed'({2'b00, r_eff});
		end else begin
			m_c = signed'({2'b00, fall}) - signed'({1'b0, k, 1'b0})
				+ signed'({1'b0, r_eff, 1'b0});
		end
	end

	// numerator with half the denominator added for rounding
	assign n_c = prod_q + signed'(prtg_pkg::MUL_PW'(h_q));

	// floor of the quotient, add offset, saturate
	always_comb begin
		qmag = Q_W'(div_quot) + Q_W'(neg_q && (div_rem != '0));
		qv   = neg_q ? -signed'(qmag) : signed'(qmag);
		v    = VW'(offset_q) + VW'(qv);
		if (v > VMAX) begin
			v_sat  = VMAX;
			clip_c = 1'b1;
		end else if (v < VMIN) begin
			v_sat  = VMIN;
			clip_c = 1'b1;
		end else begin
			v_sat  = v;
			clip_c = 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctl.ld_prod) begin
			prod_q <= prod_c;
		end
		if (ctl.ld_d) begin
			d_q <= d_c;
		end
		if (ctl.ld_shift) begin
			shift_q <= (d_q[D_W-1] && (rem_p != '0)) ? (p_eff - rem_p) : rem_p;
		end
		if (ctl.ld_phase) begin
			m_q <= m_c;
			h_q <= rising ? r_eff : fall;
		end
		if (ctl.ld_abs) begin
			neg_q  <= n_c[prtg_pkg::MUL_PW-1];
			nabs_q <= prtg_pkg::DIV_NW'(n_c[prtg_pkg::MUL_PW-1] ? -n_c : n_c);
		end
		if (ctl.ld_out) begin
			oval_q  <= v_sat[SAMPLE_BITS-1:0];
			ope_q   <= pe_q;
			oclip_q <= clip_c;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.ld_out) begin
			ovalid_q <= 1'b1;
		end else if (sample.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// sequencer
	always_comb begin
		stat.in_fire  = tick_fire;
		stat.dirty    = dirty_q;
		stat.div_done = div_done;
		stat.out_free = out_free;
	end

	prtg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign tick.ready          = ctl.ready;
	assign sample.valid        = ovalid_q;
	assign sample.sample_value = oval_q;
	assign sample.period_end   = ope_q;
	assign sample.clipped      = oclip_q;
endmodule
